### hw/rtl/ppmfd_pkg.sv
// Shared types and constants of the PPM frame decoder.
package ppmfd_pkg;

	// event kinds
	localparam logic [1:0] EV_OVERFLOW = 2'd0;
	localparam logic [1:0] EV_CAPTURE  = 2'd1;
	localparam logic [1:0] EV_QUERY    = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_SYNC_MIN  = 3'd0;
	localparam logic [2:0] CFG_SYNC_MAX  = 3'd1;
	localparam logic [2:0] CFG_PULSE_MIN = 3'd2;
	localparam logic [2:0] CFG_PULSE_MAX = 3'd3;
	localparam logic [2:0] CFG_MODE_SEL  = 3'd4;

	localparam logic [15:0] RST_SYNC_MIN  = 16'd4999;
	localparam logic [15:0] RST_SYNC_MAX  = 16'd20001;
	localparam logic [15:0] RST_PULSE_MIN = 16'd899;
	localparam logic [15:0] RST_PULSE_MAX = 16'd2101;
	localparam logic [3:0]  RST_MODE_SEL  = 4'd4;

	localparam logic [15:0] NEUTRAL_WIDTH = 16'd1500;

	// flight mode thresholds
	localparam logic [15:0] FM_MANUAL_BELOW = 16'd1100;
	localparam logic [15:0] FM_STAB_ABOVE   = 16'd1400;
	localparam logic [15:0] FM_STAB_BELOW   = 16'd1600;
	localparam logic [15:0] FM_AUTO_ABOVE   = 16'd1900;

	// flight mode codes
	localparam logic [2:0] FM_RTL       = 3'd0;
	localparam logic [2:0] FM_MANUAL    = 3'd1;
	localparam logic [2:0] FM_STABILIZE = 3'd2;
	localparam logic [2:0] FM_AUTO      = 3'd3;
	localparam logic [2:0] FM_UNDEFINED = 3'd4;

	// overflow counter: saturation point and the count that voids a length
	localparam logic signed [2:0] OVF_SAT   = 3'sd3;
	localparam logic signed [2:0] OVF_LIMIT = 3'sd2;

	// channel address field, wide enough for sixteen channels
	localparam int CH_ADDR_W = 4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] capture_time;
		logic [7:0]  read_channel;
	} in_item_t;

	typedef struct packed {
		logic [15:0] channel_value;
		logic [4:0]  signal_level;
		logic [2:0]  flight_mode;
		logic        frame_accepted;
	} out_item_t;

	typedef struct packed {
		logic [15:0] sync_min;
		logic [15:0] sync_max;
		logic [15:0] pulse_min;
		logic [15:0] pulse_max;
		logic [3:0]  mode_sel;
	} cfg_t;

	// frame control to width store
	typedef struct packed {
		logic                 we;
		logic                 wbank;
		logic [CH_ADDR_W-1:0] waddr;
		logic [15:0]          wdata;
		logic                 rbank;
		logic                 filled;
	} store_ctl_t;

endpackage

### hw/rtl/ppm_frame_decoder.sv
// Top level of the PPM frame decoder: input register, frame logic, result register.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | in_item: mode, capture_time, read_channel
//  out     | out_valid / out_stall| out_item: channel_value, signal_level,
//          |                      |   flight_mode, frame_accepted
//  cfg     | cfg_valid / cfg_ready| cfg_index (0..4), cfg_data
//
// One item per cycle sustained while the output is not stalled; an item waits in
// the input register until the result register can take it, and its result is then
// registered there; width reads come from the two-bank memory read ports.
// The frame state advances as an item leaves the input register, so the next
// item already sees it. Reset clears all control state and shows the neutral
// width on every channel until the first good frame. A stalled output holds its
// result; the input takes a new item as long as the input register can drain.
module ppm_frame_decoder #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ppmfd_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ppmfd_pkg::out_item_t out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import ppmfd_pkg::*;

	localparam int LVL_W = $clog2(NUM_CHANNELS + 1);

	in_item_t   item_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic [LVL_W-1:0] level_s2;
	logic       accepted_s2;

	cfg_t             cfg;
	store_ctl_t       ctl;
	logic             advance;
	logic             proc;
	logic             accepted;
	logic [LVL_W-1:0] level_next;
	logic [15:0]      channel_width;
	logic [15:0]      mode_width;
	logic [2:0]       fmode;

	// advance whenever the result register is empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// configuration is always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			level_s2    <= level_next;
			accepted_s2 <= accepted;
		end
	end

	ppmfd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	ppmfd_frame_ctrl #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.LVL_W        (LVL_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.proc       (proc),
		.item       (item_s1),
		.cfg        (cfg),
		.ctl        (ctl),
		.accepted   (accepted),
		.level_next (level_next)
	);

	ppmfd_width_store #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.proc          (proc),
		.ctl           (ctl),
		.read_channel  (item_s1.read_channel),
		.mode_sel      (cfg.mode_sel),
		.channel_width (channel_width),
		.mode_width    (mode_width)
	);

	// flight mode from the mode channel width; no signal forces return to launch
	always_comb begin
		if (level_s2 == '0)
			fmode = FM_RTL;
		else if (mode_width < FM_MANUAL_BELOW)
			fmode = FM_MANUAL;
		else if (mode_width > FM_STAB_ABOVE && mode_width < FM_STAB_BELOW)
			fmode = FM_STABILIZE;
		else if (mode_width > FM_AUTO_ABOVE)
			fmode = FM_AUTO;
		else
			fmode = FM_UNDEFINED;
	end

	assign out_valid               = out_valid_q;
	assign out_item.channel_value  = channel_width;
	assign out_item.signal_level   = 5'(level_s2);
	assign out_item.flight_mode    = fmode;
	assign out_item.frame_accepted = accepted_s2;

endmodule

### hw/rtl/ppmfd_cfg_regs.sv
// Configuration registers of the PPM frame decoder.
module ppmfd_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [2:0]          index,
	input  logic [15:0]         data,
	output ppmfd_pkg::cfg_t     cfg
);
	import ppmfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_min  <= RST_SYNC_MIN;
			cfg_q.sync_max  <= RST_SYNC_MAX;
			cfg_q.pulse_min <= RST_PULSE_MIN;
			cfg_q.pulse_max <= RST_PULSE_MAX;
			cfg_q.mode_sel  <= RST_MODE_SEL;
		end else if (we) begin
			case (index)
				CFG_SYNC_MIN:  cfg_q.sync_min  <= data;
				CFG_SYNC_MAX:  cfg_q.sync_max  <= data;
				CFG_PULSE_MIN: cfg_q.pulse_min <= data;
				CFG_PULSE_MAX: cfg_q.pulse_max <= data;
				CFG_MODE_SEL:  cfg_q.mode_sel  <= data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/ppmfd_frame_ctrl.sv
// Pulse timing, sync search, channel counting and bank flip of the decoder.
module ppmfd_frame_ctrl #(
	parameter int NUM_CHANNELS = 8,
	parameter int LVL_W        = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  proc,
	input  ppmfd_pkg::in_item_t   item,
	input  ppmfd_pkg::cfg_t       cfg,
	output ppmfd_pkg::store_ctl_t ctl,
	output logic                  accepted,
	output logic [LVL_W-1:0]      level_next
);
	import ppmfd_pkg::*;

	logic signed [2:0] ovf_q;
	logic [15:0]       prev_q;
	logic [LVL_W-1:0]  idx_q;
	logic [LVL_W-1:0]  good_q;
	logic [LVL_W-1:0]  level_q;
	logic              sel_q;
	logic              filled_q;

	logic        is_cap;
	logic        waiting;
	logic [15:0] len;
	logic        sync_ok;
	logic        pulse_ok;
	logic        frame_full;

	assign is_cap     = proc && (item.mode == EV_CAPTURE);
	assign waiting    = idx_q >= LVL_W'(NUM_CHANNELS);
	assign len        = (ovf_q < OVF_LIMIT) ? (item.capture_time - prev_q) : 16'd0;
	assign sync_ok    = (len > cfg.sync_min) && (len < cfg.sync_max);
	assign pulse_ok   = (len > cfg.pulse_min) && (len < cfg.pulse_max);
	assign frame_full = good_q == LVL_W'(NUM_CHANNELS);
	assign accepted   = is_cap && waiting && sync_ok && frame_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q    <= -3'sd1;
			prev_q   <= '0;
			idx_q    <= LVL_W'(NUM_CHANNELS);
			good_q   <= '0;
			level_q  <= '0;
			sel_q    <= 1'b0;
			filled_q <= 1'b0;
		end else if (proc) begin
			case (item.mode)
				EV_OVERFLOW: begin
					if (ovf_q < OVF_SAT)
						ovf_q <= ovf_q + 3'sd1;
				end
				EV_CAPTURE: begin
					prev_q <= item.capture_time;
					ovf_q  <= 3'sd0;
					if (waiting) begin
						if (sync_ok)
							idx_q <= '0;
						if (accepted) begin
							sel_q    <= ~sel_q;
							filled_q <= 1'b1;
						end
						level_q <= good_q;
						good_q  <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (pulse_ok)
							good_q <= good_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// pending lengths go to the bank that is not on display
	assign ctl.we     = is_cap && !waiting;
	assign ctl.wbank  = ~sel_q;
	assign ctl.waddr  = CH_ADDR_W'(idx_q);
	assign ctl.wdata  = len;
	assign ctl.rbank  = accepted ? ~sel_q : sel_q;
	assign ctl.filled = filled_q || accepted;

	assign level_next = (is_cap && waiting) ? good_q : level_q;

endmodule

### hw/rtl/ppmfd_width_store.sv
// Two-bank channel width memory with registered reads for the decoder.
module ppmfd_width_store #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  proc,
	input  ppmfd_pkg::store_ctl_t ctl,
	input  logic [7:0]            read_channel,
	input  logic [3:0]            mode_sel,
	output logic [15:0]           channel_width,
	output logic [15:0]           mode_width
);
	import ppmfd_pkg::*;

	localparam int DEPTH  = 2 * NUM_CHANNELS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [15:0] mem [DEPTH];

	logic [15:0]       ch_rd_q;
	logic [15:0]       md_rd_q;
	logic              ch_ok_q;
	logic              md_ok_q;
	logic              ch_in;
	logic              md_in;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] ch_addr;
	logic [ADDR_W-1:0] md_addr;

	function automatic logic [ADDR_W-1:0] map_addr(input logic bank,
			input logic [CH_W-1:0] idx);
		map_addr = ADDR_W'(idx) + (bank ? ADDR_W'(NUM_CHANNELS) : '0);
	endfunction

	assign ch_in   = read_channel < 8'(NUM_CHANNELS);
	assign md_in   = {1'b0, mode_sel} < 5'(NUM_CHANNELS);
	assign waddr   = map_addr(ctl.wbank, ctl.waddr[CH_W-1:0]);
	assign ch_addr = map_addr(ctl.rbank, read_channel[CH_W-1:0]);
	assign md_addr = map_addr(ctl.rbank, mode_sel[CH_W-1:0]);

	always_ff @(posedge clk) begin
		if (proc && ctl.we)
			mem[waddr] <= ctl.wdata;
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			ch_rd_q <= mem[ch_addr];
			md_rd_q <= mem[md_addr];
		end
	end

	// before the first good frame, or out of range, read neutral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_ok_q <= 1'b0;
			md_ok_q <= 1'b0;
		end else if (proc) begin
			ch_ok_q <= ctl.filled && ch_in;
			md_ok_q <= ctl.filled && md_in;
		end
	end

	assign channel_width = ch_ok_q ? ch_rd_q : NEUTRAL_WIDTH;
	assign mode_width    = md_ok_q ? md_rd_q : NEUTRAL_WIDTH;

endmodule

### sim/tb_ppm_frame_decoder.sv
// Self-checking testbench of the PPM frame decoder: predicts each result item and checks the block.
module tb_ppm_frame_decoder;
	import ppmfd_pkg::*;

	// Tracks the decoder state, predicts one result per accepted event and compares results in order.
	class ppm_result_checker;
		localparam int NCH = 8;
		localparam int REPORT_MAX = 10;

		cfg_t              regs;
		logic signed [2:0] wraps;
		logic [15:0]       last_capture;
		int unsigned       slot;
		int unsigned       good_pulses;
		logic [15:0]       pending_w [NCH];
		logic [15:0]       stored_w [NCH];
		logic [4:0]        level;
		out_item_t         pending_results [$];
		int unsigned       mismatches;
		int unsigned       checked;
		int unsigned       frames;

		function new();
			regs.sync_min  = RST_SYNC_MIN;
			regs.sync_max  = RST_SYNC_MAX;
			regs.pulse_min = RST_PULSE_MIN;
			regs.pulse_max = RST_PULSE_MAX;
			regs.mode_sel  = RST_MODE_SEL;
			wraps        = -3'sd1;
			last_capture = '0;
			slot         = NCH;
			good_pulses  = 0;
			level        = '0;
			mismatches   = 0;
			checked      = 0;
			frames       = 0;
			for (int i = 0; i < NCH; i++) begin
				pending_w[i] = '0;
				stored_w[i]  = NEUTRAL_WIDTH;
			end
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				CFG_SYNC_MIN:  regs.sync_min = data;
				CFG_SYNC_MAX:  regs.sync_max = data;
				CFG_PULSE_MIN: regs.pulse_min = data;
				CFG_PULSE_MAX: regs.pulse_max = data;
				CFG_MODE_SEL:  regs.mode_sel = data[3:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] width_at(int unsigned ch);
			return (ch < NCH) ? stored_w[ch] : NEUTRAL_WIDTH;
		endfunction

		// Advance the state by one accepted event and queue the result it must produce.
		function void note_event(in_item_t ev);
			logic [15:0] gap;
			logic [15:0] w;
			out_item_t   res;
			res.frame_accepted = 1'b0;
			if (ev.mode == EV_OVERFLOW) begin
				if (wraps < OVF_SAT)
					wraps = wraps + 3'sd1;
			end else if (ev.mode == EV_CAPTURE) begin
				gap = (wraps < OVF_LIMIT) ? ev.capture_time - last_capture : 16'd0;
				last_capture = ev.capture_time;
				wraps = 3'sd0;
				if (slot >= NCH) begin
					if (gap > regs.sync_min && gap < regs.sync_max) begin
						slot = 0;
						if (good_pulses == NCH) begin
							stored_w = pending_w;
							res.frame_accepted = 1'b1;
							frames++;
						end
					end
					level = 5'(good_pulses);
					good_pulses = 0;
				end else begin
					pending_w[slot] = gap;
					slot++;
					if (gap > regs.pulse_min && gap < regs.pulse_max)
						good_pulses++;
				end
			end
			res.channel_value = width_at(ev.read_channel);
			res.signal_level  = level;
			w = width_at(regs.mode_sel);
			if (level == 0)
				res.flight_mode = FM_RTL;
			else if (w < FM_MANUAL_BELOW)
				res.flight_mode = FM_MANUAL;
			else if (w > FM_STAB_ABOVE && w < FM_STAB_BELOW)
				res.flight_mode = FM_STABILIZE;
			else if (w > FM_AUTO_ABOVE)
				res.flight_mode = FM_AUTO;
			else
				res.flight_mode = FM_UNDEFINED;
			pending_results.push_back(res);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result item: value %0d level %0d mode %0d accepted %0b",
						got.channel_value, got.signal_level, got.flight_mode, got.frame_accepted);
				return;
			end
			want = pending_results.pop_front();
			if (got.channel_value !== want.channel_value || got.signal_level !== want.signal_level ||
			    got.flight_mode !== want.flight_mode || got.frame_accepted !== want.frame_accepted) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("result %0d mismatch: value %0d/%0d level %0d/%0d mode %0d/%0d",
						checked, got.channel_value, want.channel_value, got.signal_level,
						want.signal_level, got.flight_mode, want.flight_mode);
					$display("  frame accepted %0b, predicted %0b",
						got.frame_accepted, want.frame_accepted);
				end
			end
		endfunction
	endclass

	localparam int NCH            = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 6;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 235;
	// the fourth event kind has no meaning and must act as a plain query
	localparam logic [1:0] EV_SPARE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned events_sent;
	int unsigned reg_writes;
	int unsigned quiet_cycles;
	logic [15:0] timer_now;

	ppm_result_checker frame_check;

	ppm_frame_decoder #(
		.NUM_CHANNELS(NCH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver side: draw a new stall decision every falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Check every result item as it is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			frame_check.check_result(out_item);
	end

	// Watchdog: end the run when no channel moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("ppm_frame_decoder regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one event, idling at random first, and hold it until the block takes it.
	task automatic send_event(logic [1:0] kind, logic [15:0] stamp, logic [7:0] ch);
		in_item_t ev;
		ev.mode         = kind;
		ev.capture_time = stamp;
		ev.read_channel = ch;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= ev;
		do @(posedge clk); while (in_stall);
		frame_check.note_event(ev);
		events_sent++;
	endtask

	// Write one register and hand the new value to the predictor once it is taken.
	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		frame_check.set_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid and wait until every predicted result has come out and the pipe is empty.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frame_check.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly the first channels and the first index past the end, now and then any index.
	function automatic logic [7:0] pick_channel();
		if ($urandom_range(9) < 8)
			return 8'($urandom_range(NCH));
		return 8'($urandom_range(255));
	endfunction

	// A length strictly inside (lo, hi), often right on an edge; any length if the window is empty.
	function automatic logic [15:0] between(logic [15:0] lo, logic [15:0] hi);
		if (int'(hi) - int'(lo) < 2)
			return 16'($urandom);
		case ($urandom_range(5))
			0:       return lo + 16'd1;
			1:       return hi - 16'd1;
			default: return 16'($urandom_range(int'(hi) - 1, int'(lo) + 1));
		endcase
	endfunction

	// A length on a limit or anywhere at all.
	function automatic logic [15:0] outside(logic [15:0] lo, logic [15:0] hi);
		case ($urandom_range(3))
			0:       return lo;
			1:       return hi;
			default: return 16'($urandom);
		endcase
	endfunction

	// A width on either side of one of the flight mode thresholds.
	function automatic logic [15:0] mode_mark();
		case ($urandom_range(7))
			0:       return FM_MANUAL_BELOW - 16'd1;
			1:       return FM_MANUAL_BELOW;
			2:       return FM_STAB_ABOVE;
			3:       return FM_STAB_ABOVE + 16'd1;
			4:       return FM_STAB_BELOW - 16'd1;
			5:       return FM_STAB_BELOW;
			6:       return FM_AUTO_ABOVE;
			default: return FM_AUTO_ABOVE + 16'd1;
		endcase
	endfunction

	// Capture an edge gap ticks after the last one; with noise, wraps and queries go first.
	task automatic capture_after(logic [15:0] gap, bit noisy);
		int unsigned roll;
		if (noisy) begin
			roll = $urandom_range(99);
			if (roll < 8)
				send_event(EV_OVERFLOW, 16'($urandom), pick_channel());
			else if (roll < 11)
				repeat ($urandom_range(4, 2)) send_event(EV_OVERFLOW, 16'($urandom), pick_channel());
			if ($urandom_range(99) < 15)
				send_event(EV_QUERY, 16'($urandom), pick_channel());
		end
		timer_now = timer_now + gap;
		send_event(EV_CAPTURE, timer_now, pick_channel());
	endtask

	// One frame: a sync gap, then the channel pulses. Some syncs are off and some frames
	// break off early, so the decoder has to find its way back to sync.
	task automatic send_frame();
		int unsigned pulses;
		logic [15:0] w;
		cfg_t        r;
		r = frame_check.regs;
		if ($urandom_range(9) == 0)
			capture_after(outside(r.sync_min, r.sync_max), 1'b1);
		else
			capture_after(between(r.sync_min, r.sync_max), 1'b1);
		pulses = ($urandom_range(9) == 0) ? $urandom_range(NCH - 1) : NCH;
		repeat (pulses) begin
			if ($urandom_range(19) == 0) begin
				w = outside(r.pulse_min, r.pulse_max);
			end else if ($urandom_range(9) < 4) begin
				w = mode_mark();
				if (!(w > r.pulse_min && w < r.pulse_max))
					w = between(r.pulse_min, r.pulse_max);
			end else begin
				w = between(r.pulse_min, r.pulse_max);
			end
			capture_after(w, 1'b1);
		end
	endtask

	// A short burst of events of any kind, any time stamp and any channel index.
	task automatic send_noise();
		logic [1:0]  kind;
		logic [15:0] stamp;
		repeat ($urandom_range(5, 1)) begin
			kind  = 2'($urandom_range(3));
			stamp = 16'($urandom);
			if (kind == EV_CAPTURE)
				timer_now = stamp;
			send_event(kind, stamp, 8'($urandom));
		end
	endtask

	// Reset values first, then the widest and the narrowest windows, then settings near
	// the usual servo timing with the mode channel anywhere, out of range included.
	task automatic program_phase(int unsigned p);
		logic [15:0] smin;
		logic [15:0] smax;
		logic [15:0] pmin;
		logic [15:0] pmax;
		logic [3:0]  mc;
		case (p)
			1: begin
				smin = 16'h0000;
				smax = 16'hFFFF;
				pmin = 16'h0000;
				pmax = 16'hFFFF;
				mc   = 4'd15;
			end
			2: begin
				smin = 16'hFFFF;
				smax = 16'h0000;
				pmin = 16'hFFFF;
				pmax = 16'h0000;
				mc   = 4'd0;
			end
			3: begin
				smin = RST_SYNC_MIN;
				smax = RST_SYNC_MAX;
				pmin = RST_PULSE_MIN;
				pmax = RST_PULSE_MAX;
				mc   = 4'(NCH - 1);
			end
			default: begin
				smin = 16'($urandom_range(6000, 3000));
				smax = 16'($urandom_range(25000, 15000));
				pmin = 16'($urandom_range(1000, 800));
				pmax = 16'($urandom_range(2200, 2000));
				mc   = 4'($urandom_range(15));
			end
		endcase
		write_reg(CFG_SYNC_MIN, smin);
		write_reg(CFG_SYNC_MAX, smax);
		write_reg(CFG_PULSE_MIN, pmin);
		write_reg(CFG_PULSE_MAX, pmax);
		// upper data bits have no register behind them
		write_reg(CFG_MODE_SEL, {12'($urandom), mc});
	endtask

	// Directed opening under reset settings: neutral outputs, index range, the spare kind,
	// wrap saturation, strict sync limits, a timer wrap and one clean frame taken.
	task automatic run_directed();
		send_event(EV_QUERY, 16'h0000, 8'd0);
		send_event(EV_QUERY, 16'hFFFF, 8'hFF);
		send_event(EV_SPARE, 16'hA5A5, 8'd8);
		repeat (4) send_event(EV_OVERFLOW, 16'h0000, 8'd1);
		// too many wraps since the last edge: the length is void
		timer_now = 16'hFFFF;
		send_event(EV_CAPTURE, timer_now, 8'd7);
		// exactly on either sync limit is no sync, the first across zero; one above the minimum is
		capture_after(RST_SYNC_MIN, 1'b0);
		capture_after(RST_SYNC_MAX, 1'b0);
		capture_after(RST_SYNC_MIN + 16'd1, 1'b0);
		capture_after(RST_PULSE_MIN + 16'd1, 1'b0);
		capture_after(RST_PULSE_MAX - 16'd1, 1'b0);
		capture_after(16'd1500, 1'b0);
		capture_after(16'd1000, 1'b0);
		capture_after(16'd1450, 1'b0);
		capture_after(16'd1200, 1'b0);
		capture_after(16'd1800, 1'b0);
		capture_after(16'd2000, 1'b0);
		// the closing sync copies the frame and sets the level to eight
		capture_after(RST_SYNC_MAX - 16'd1, 1'b0);
		send_event(EV_QUERY, 16'h0000, 8'd4);
		send_event(EV_QUERY, 16'h0000, 8'(NCH - 1));
		send_event(EV_QUERY, 16'h0000, 8'(NCH));
	endtask

	initial begin
		int unsigned target;
		frame_check  = new();
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_item      = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_SYNC_MIN;
		cfg_data     = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		events_sent  = 0;
		reg_writes   = 0;
		timer_now    = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				settle();
				program_phase(p);
			end
			// rotate idling: none, sender idle, receiver stalling, both lightly
			case (p % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 87;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 87;
				end
				default: begin
					idle_pct  = 18;
					stall_pct = 18;
				end
			endcase
			target = events_sent + PHASE_ITEMS;
			while (events_sent < target) begin
				if ($urandom_range(4) == 0)
					send_noise();
				else
					send_frame();
			end
		end
		settle();

		$display("covered %0d timer events over %0d phases with %0d register writes",
			events_sent, PHASES, reg_writes);
		$display("checked %0d results, %0d complete frames stored, %0d mismatches",
			frame_check.checked, frame_check.frames, frame_check.mismatches);
		if (frame_check.mismatches == 0 && frame_check.pending_results.size() == 0)
			$display("ppm_frame_decoder regression: pass");
		else
			$display("ppm_frame_decoder regression: fail");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/ppmfd_pkg.sv
hw/rtl/ppmfd_cfg_regs.sv
hw/rtl/ppmfd_frame_ctrl.sv
hw/rtl/ppmfd_width_store.sv
hw/rtl/ppm_frame_decoder.sv
sim/tb_ppm_frame_decoder.sv
